// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on clk with an active-low reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("Assertion failed.");

// Same assertion on the standard clk_i and rst_ni of a module.
`define ASSERT_STD(label, prop) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

// ===== hdl/yrgb_pkg.sv =====
// Types, register indexes and arithmetic helpers for the YUYV to RGB converter.
// No dependencies.
package yrgb_pkg;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 48;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LUMA_OFFSET   = 4'd0,
    REG_CHROMA_OFFSET = 4'd1,
    REG_LUMA_GAIN     = 4'd2,
    REG_BLUE_FROM_U   = 4'd3,
    REG_GREEN_FROM_U  = 4'd4,
    REG_GREEN_FROM_V  = 4'd5,
    REG_RED_FROM_V    = 4'd6,
    REG_SCALE_SHIFT   = 4'd7
  } reg_idx_e;

  typedef struct packed {
    logic        [7:0]  luma_offset;
    logic        [7:0]  chroma_offset;
    logic signed [15:0] luma_gain;
    logic signed [15:0] blue_from_u;
    logic signed [15:0] green_from_u;
    logic signed [15:0] green_from_v;
    logic signed [15:0] red_from_v;
    logic        [3:0]  scale_shift;
  } cfg_t;

  function automatic logic signed [8:0] sub_offset(input logic [7:0] s, input logic [7:0] off);
    return $signed({1'b0, s}) - $signed({1'b0, off});
  endfunction

  function automatic logic signed [15:0] mul_lo16(input logic signed [8:0] a,
                                                  input logic signed [15:0] b);
    logic signed [24:0] p;
    p = a * b;
    return p[15:0];
  endfunction

  function automatic logic signed [15:0] sat17(input logic signed [16:0] s);
    if (s[16] != s[15]) begin
      return s[16] ? 16'sh8000 : 16'sh7fff;
    end
    return s[15:0];
  endfunction

  function automatic logic signed [15:0] add_sat(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    return sat17({a[15], a} + {b[15], b});
  endfunction

  function automatic logic signed [15:0] sub_sat(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    return sat17({a[15], a} - {b[15], b});
  endfunction

  function automatic logic [7:0] shift_clamp(input logic signed [15:0] v,
                                             input logic [3:0] sh);
    logic signed [15:0] t;
    t = v >>> sh;
    if (t[15]) begin
      return 8'd0;
    end
    if (t[14:8] != 7'd0) begin
      return 8'hff;
    end
    return t[7:0];
  endfunction

endpackage

// ===== hdl/yuy2_to_rgb_color_convert.sv =====
// Top level of the YUYV macropixel to RGB converter: five-stage pipeline.
// Depends on yrgb_pkg and yrgb_cfg_regs.
//
// Usage: each word on the slave stream is one YUYV macropixel; each word on
// the master stream is the two RGB pixels made from it, in the same order.
// Registers are written on the configuration channel, which is always ready;
// write them only while no word is in flight.
// The five pipeline stages are offset subtraction, the gain multipliers, the
// chroma and channel sums, the green difference, and the shift and clamp into
// the output register; an accepted word passes through them in order, and the
// output register holds it for the master side until it is taken.
// Throughput is one word per cycle while the receiver does not stall.
// At reset every stage is emptied and the registers take their default values.
// When the receiver stalls, the output register holds its word and each stage
// behind it keeps advancing into empty slots; once all five are full,
// s_axis_tready falls, and no word is dropped or repeated.
module yuy2_to_rgb_color_convert (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // Fields from bit 0: luma_first, chroma_blue, luma_second, chroma_red.
  input  logic [yrgb_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // Fields from bit 0: blue_first, green_first, red_first,
  // blue_second, green_second, red_second.
  output logic [yrgb_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [yrgb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [yrgb_pkg::CfgDataW-1:0]  cfg_data_i
);
  import yrgb_pkg::*;

  cfg_t cfg;

  yrgb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign cfg_ready_o = 1'b1;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || m_axis_tready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  logic signed [8:0]  ya1_q, yb1_q, u1_q, v1c_q;
  logic signed [15:0] luma_a2_q, luma_b2_q, bu2_q, gu2_q, gv2_q, rv2_q;
  logic signed [15:0] luma_a3_q, luma_b3_q, guv3_q;
  logic signed [15:0] blue_a3_q, blue_b3_q, red_a3_q, red_b3_q;
  logic signed [15:0] blue_a4_q, blue_b4_q, red_a4_q, red_b4_q;
  logic signed [15:0] green_a4_q, green_b4_q;
  logic [OutDataW-1:0] out5_q;

  always_ff @(posedge clk_i) begin
    if (en1 && s_axis_tvalid) begin
      ya1_q <= sub_offset(s_axis_tdata[7:0], cfg.luma_offset);
      u1_q  <= sub_offset(s_axis_tdata[15:8], cfg.chroma_offset);
      yb1_q <= sub_offset(s_axis_tdata[23:16], cfg.luma_offset);
      v1c_q <= sub_offset(s_axis_tdata[31:24], cfg.chroma_offset);
    end
    if (en2 && v1_q) begin
      luma_a2_q <= mul_lo16(ya1_q, cfg.luma_gain);
      luma_b2_q <= mul_lo16(yb1_q, cfg.luma_gain);
      bu2_q     <= mul_lo16(u1_q, cfg.blue_from_u);
      gu2_q     <= mul_lo16(u1_q, cfg.green_from_u);
      gv2_q     <= mul_lo16(v1c_q, cfg.green_from_v);
      rv2_q     <= mul_lo16(v1c_q, cfg.red_from_v);
    end
    if (en3 && v2_q) begin
      luma_a3_q <= luma_a2_q;
      luma_b3_q <= luma_b2_q;
      guv3_q    <= add_sat(gu2_q, gv2_q);
      blue_a3_q <= add_sat(luma_a2_q, bu2_q);
      blue_b3_q <= add_sat(luma_b2_q, bu2_q);
      red_a3_q  <= add_sat(luma_a2_q, rv2_q);
      red_b3_q  <= add_sat(luma_b2_q, rv2_q);
    end
    if (en4 && v3_q) begin
      green_a4_q <= sub_sat(luma_a3_q, guv3_q);
      green_b4_q <= sub_sat(luma_b3_q, guv3_q);
      blue_a4_q  <= blue_a3_q;
      blue_b4_q  <= blue_b3_q;
      red_a4_q   <= red_a3_q;
      red_b4_q   <= red_b3_q;
    end
    if (en5 && v4_q) begin
      out5_q <= {shift_clamp(red_b4_q, cfg.scale_shift),
                 shift_clamp(green_b4_q, cfg.scale_shift),
                 shift_clamp(blue_b4_q, cfg.scale_shift),
                 shift_clamp(red_a4_q, cfg.scale_shift),
                 shift_clamp(green_a4_q, cfg.scale_shift),
                 shift_clamp(blue_a4_q, cfg.scale_shift)};
    end
  end

  assign m_axis_tvalid = v5_q;
  assign m_axis_tdata  = out5_q;

endmodule

// ===== hdl/yrgb_cfg_regs.sv =====
// Configuration register file of the YUYV to RGB converter.
// Depends on yrgb_pkg.
module yrgb_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [yrgb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [yrgb_pkg::CfgDataW-1:0]  cfg_data_i,
  output yrgb_pkg::cfg_t                 cfg_o
);
  import yrgb_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_LUMA_OFFSET:   cfg_d.luma_offset   = cfg_data_i[7:0];
        REG_CHROMA_OFFSET: cfg_d.chroma_offset = cfg_data_i[7:0];
        REG_LUMA_GAIN:     cfg_d.luma_gain     = cfg_data_i;
        REG_BLUE_FROM_U:   cfg_d.blue_from_u   = cfg_data_i;
        REG_GREEN_FROM_U:  cfg_d.green_from_u  = cfg_data_i;
        REG_GREEN_FROM_V:  cfg_d.green_from_v  = cfg_data_i;
        REG_RED_FROM_V:    cfg_d.red_from_v    = cfg_data_i;
        REG_SCALE_SHIFT:   cfg_d.scale_shift   = cfg_data_i[3:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.luma_offset   <= 8'd16;
      cfg_q.chroma_offset <= 8'd128;
      cfg_q.luma_gain     <= 16'sd75;
      cfg_q.blue_from_u   <= 16'sd129;
      cfg_q.green_from_u  <= 16'sd25;
      cfg_q.green_from_v  <= 16'sd52;
      cfg_q.red_from_v    <= 16'sd102;
      cfg_q.scale_shift   <= 4'd6;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/yrgb_checker.sv =====
// Port-level checker of the YUYV to RGB converter, bound to its top level.
// Depends on yrgb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module yrgb_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [yrgb_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam logic [2:0] PipeDepth = 3'd5;

  logic       in_acc, out_acc;
  logic [2:0] occ_q, occ_d;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    occ_d = occ_q;
    if (in_acc && !out_acc) begin
      occ_d = occ_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      occ_d = occ_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 3'd0;
    end else begin
      occ_q <= occ_d;
    end
  end

  `ASSERT_STD(a_out_valid_holds, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `ASSERT_STD(a_out_data_holds, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
  `ASSERT_STD(a_no_invented_word, out_acc |-> occ_q != 3'd0)
  `ASSERT_STD(a_occupancy_bound, occ_q <= PipeDepth)

endmodule

bind yuy2_to_rgb_color_convert yrgb_checker u_yrgb_checker (.*);

// ===== tb/yuy2_to_rgb_color_convert_tb.sv =====
// Self-checking testbench for the YUYV to RGB color converter.
// Depends on yrgb_pkg and yuy2_to_rgb_color_convert; drives both streams and
// the register channel and predicts every RGB word with its own arithmetic.
module yuy2_to_rgb_color_convert_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import yrgb_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int PhaseCount = 10;
  localparam int PhaseWords = 93;
  localparam logic [CfgIdxW-1:0] FirstUnusedIdx = 4'd8;
  localparam logic [CfgIdxW-1:0] LastUnusedIdx = 4'd15;

  localparam cfg_t ResetSettings = '{
    luma_offset: 8'd16, chroma_offset: 8'd128, luma_gain: 16'sd75,
    blue_from_u: 16'sd129, green_from_u: 16'sd25, green_from_v: 16'sd52,
    red_from_v: 16'sd102, scale_shift: 4'd6
  };

  typedef enum int {
    SET_NATURAL,
    SET_ANY,
    SET_EXTREME
  } setting_kind_e;

  typedef struct packed {
    logic [7:0] chroma_red;
    logic [7:0] luma_second;
    logic [7:0] chroma_blue;
    logic [7:0] luma_first;
  } yuyv_t;

  typedef struct packed {
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
  } rgb_pair_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  cfg_t      cur_cfg = ResetSettings;
  rgb_pair_t expected_rgb[$];
  int        error_count = 0;
  int        burst_left = 0;
  bit        steady_sender = 1'b0;
  int        stall_phase = 0;
  int        stall_mode = 0;
  int        quiet_cycles = 0;
  string     channel_names[6] = '{"blue_first", "green_first", "red_first",
                                  "blue_second", "green_second", "red_second"};

  yuy2_to_rgb_color_convert dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int wrap16(int v);
    logic signed [15:0] t;
    t = v[15:0];
    return t;
  endfunction

  function automatic int clip16(int v);
    if (v > 32767) begin
      return 32767;
    end
    if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  function automatic logic [7:0] clamp_byte(int v);
    if (v < 0) begin
      return 8'd0;
    end
    if (v > 255) begin
      return 8'd255;
    end
    return v[7:0];
  endfunction

  function automatic rgb_pair_t convert_macropixel(yuyv_t px);
    rgb_pair_t res;
    int uc, vc, bu, rv, guv, sh;
    int lum[2];
    uc  = clip16(int'(px.chroma_blue) - int'(cur_cfg.chroma_offset));
    vc  = clip16(int'(px.chroma_red) - int'(cur_cfg.chroma_offset));
    bu  = wrap16(uc * int'(cur_cfg.blue_from_u));
    rv  = wrap16(vc * int'(cur_cfg.red_from_v));
    guv = clip16(wrap16(uc * int'(cur_cfg.green_from_u)) +
                 wrap16(vc * int'(cur_cfg.green_from_v)));
    sh  = int'(cur_cfg.scale_shift);
    lum[0] = wrap16(clip16(int'(px.luma_first) - int'(cur_cfg.luma_offset)) *
                    int'(cur_cfg.luma_gain));
    lum[1] = wrap16(clip16(int'(px.luma_second) - int'(cur_cfg.luma_offset)) *
                    int'(cur_cfg.luma_gain));
    res.blue_first   = clamp_byte(clip16(lum[0] + bu) >>> sh);
    res.green_first  = clamp_byte(clip16(lum[0] - guv) >>> sh);
    res.red_first    = clamp_byte(clip16(lum[0] + rv) >>> sh);
    res.blue_second  = clamp_byte(clip16(lum[1] + bu) >>> sh);
    res.green_second = clamp_byte(clip16(lum[1] - guv) >>> sh);
    res.red_second   = clamp_byte(clip16(lum[1] + rv) >>> sh);
    return res;
  endfunction

  function automatic logic signed [15:0] extreme_gain();
    case ($urandom_range(0, 4))
      0: return -16'sd32768;
      1: return -16'sd1;
      2: return 16'sd0;
      3: return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  function automatic cfg_t pick_settings(setting_kind_e kind);
    cfg_t s;
    case (kind)
      SET_NATURAL: begin
        s.luma_offset   = 8'($urandom_range(0, 32));
        s.chroma_offset = 8'($urandom_range(96, 160));
        s.luma_gain     = 16'($urandom_range(32, 128));
        s.blue_from_u   = 16'($urandom_range(64, 200));
        s.green_from_u  = 16'($urandom_range(0, 64));
        s.green_from_v  = 16'($urandom_range(16, 96));
        s.red_from_v    = 16'($urandom_range(64, 160));
        s.scale_shift   = 4'($urandom_range(5, 8));
      end
      SET_ANY: begin
        s.luma_offset   = 8'($urandom);
        s.chroma_offset = 8'($urandom);
        s.luma_gain     = 16'($urandom);
        s.blue_from_u   = 16'($urandom);
        s.green_from_u  = 16'($urandom);
        s.green_from_v  = 16'($urandom);
        s.red_from_v    = 16'($urandom);
        s.scale_shift   = 4'($urandom);
      end
      default: begin
        s.luma_offset   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        s.chroma_offset = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        s.luma_gain     = extreme_gain();
        s.blue_from_u   = extreme_gain();
        s.green_from_u  = extreme_gain();
        s.green_from_v  = extreme_gain();
        s.red_from_v    = extreme_gain();
        s.scale_shift   = $urandom_range(0, 1) ? 4'd15 : 4'd0;
      end
    endcase
    return s;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_result(logic [OutDataW-1:0] word);
    rgb_pair_t exp_px;
    if (expected_rgb.size() == 0) begin
      report_mismatch($sformatf("unexpected word %h", word));
      return;
    end
    exp_px = expected_rgb.pop_front();
    for (int i = 0; i < 6; i++) begin
      if (word[8*i +: 8] !== exp_px[8*i +: 8]) begin
        report_mismatch($sformatf("%s expected %0d got %0d", channel_names[i],
                                  exp_px[8*i +: 8], word[8*i +: 8]));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_result(m_axis_tdata);
    end
    stall_phase++;
    if (stall_phase % 64 == 0) begin
      stall_mode = $urandom_range(0, 2);
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= (stall_phase % 5 == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  task automatic send_macropixel(yuyv_t px);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_rgb.push_back(convert_macropixel(px));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = steady_sender ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_rgb.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_LUMA_OFFSET:   cur_cfg.luma_offset   = data[7:0];
      REG_CHROMA_OFFSET: cur_cfg.chroma_offset = data[7:0];
      REG_LUMA_GAIN:     cur_cfg.luma_gain     = data;
      REG_BLUE_FROM_U:   cur_cfg.blue_from_u   = data;
      REG_GREEN_FROM_U:  cur_cfg.green_from_u  = data;
      REG_GREEN_FROM_V:  cur_cfg.green_from_v  = data;
      REG_RED_FROM_V:    cur_cfg.red_from_v    = data;
      REG_SCALE_SHIFT:   cur_cfg.scale_shift   = data[3:0];
      default: ;
    endcase
  endtask

  task automatic configure(cfg_t s);
    wait_idle();
    write_reg(REG_LUMA_OFFSET, {8'($urandom), s.luma_offset});
    write_reg(REG_CHROMA_OFFSET, {8'($urandom), s.chroma_offset});
    write_reg(REG_LUMA_GAIN, s.luma_gain);
    write_reg(REG_BLUE_FROM_U, s.blue_from_u);
    write_reg(REG_GREEN_FROM_U, s.green_from_u);
    write_reg(REG_GREEN_FROM_V, s.green_from_v);
    write_reg(REG_RED_FROM_V, s.red_from_v);
    write_reg(REG_SCALE_SHIFT, {12'($urandom), s.scale_shift});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_default_conversion();
    send_macropixel('{8'd0, 8'd0, 8'd0, 8'd0});
    send_macropixel('{8'd255, 8'd255, 8'd255, 8'd255});
    send_macropixel('{8'd255, 8'd0, 8'd255, 8'd0});
    send_macropixel('{8'd0, 8'd255, 8'd0, 8'd255});
    send_macropixel('{8'd128, 8'd235, 8'd128, 8'd16});
    send_macropixel('{8'd128, 8'd128, 8'd128, 8'd128});
  endtask

  task automatic test_product_wrap();
    cfg_t s;
    s = '{luma_offset: 8'd0, chroma_offset: 8'd0, luma_gain: 16'sd32767,
          blue_from_u: -16'sd32768, green_from_u: 16'sd300,
          green_from_v: -16'sd300, red_from_v: 16'sd1000, scale_shift: 4'd0};
    configure(s);
    send_macropixel('{8'd255, 8'd255, 8'd255, 8'd255});
    send_macropixel('{8'd4, 8'd3, 8'd2, 8'd1});
    send_macropixel('{8'd250, 8'd129, 8'd77, 8'd200});
  endtask

  task automatic test_sum_saturation();
    cfg_t s;
    s = '{luma_offset: 8'd128, chroma_offset: 8'd255, luma_gain: 16'sd128,
          blue_from_u: -16'sd128, green_from_u: 16'sd128,
          green_from_v: 16'sd128, red_from_v: 16'sd128, scale_shift: 4'd7};
    for (int pass = 0; pass < 2; pass++) begin
      configure(s);
      send_macropixel('{8'd0, 8'd255, 8'd0, 8'd255});
      send_macropixel('{8'd0, 8'd0, 8'd0, 8'd0});
      send_macropixel('{8'd255, 8'd0, 8'd255, 8'd128});
      s.scale_shift = 4'd15;
    end
  endtask

  task automatic test_register_masking();
    configure(ResetSettings);
    @(posedge clk_i);
    write_reg(REG_LUMA_OFFSET, 16'hA510);
    write_reg(REG_CHROMA_OFFSET, 16'h3C70);
    write_reg(REG_SCALE_SHIFT, 16'hFFF5);
    write_reg(FirstUnusedIdx, 16'($urandom));
    write_reg(LastUnusedIdx, 16'($urandom));
    cfg_valid_i <= 1'b0;
    send_macropixel('{8'd200, 8'd16, 8'd60, 8'd235});
    send_macropixel('{8'd0, 8'd255, 8'd255, 8'd0});
    send_macropixel('{8'd112, 8'd90, 8'd180, 8'd81});
    send_macropixel('{8'd255, 8'd1, 8'd0, 8'd254});
  endtask

  task automatic test_random_streams();
    setting_kind_e kind;
    for (int phase = 0; phase < PhaseCount; phase++) begin
      kind = setting_kind_e'(phase % 3);
      configure(pick_settings(kind));
      steady_sender = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PhaseWords; n++) begin
        send_macropixel(yuyv_t'($urandom));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_conversion();
    test_product_wrap();
    test_sum_saturation();
    test_register_masking();
    test_random_streams();
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
